// ----- rtl/mpf_pkg.sv -----
// Shared types and constants for the integer printf formatter.
package mpf_pkg;

   // Width at which the argument is read, and its clamped working width.
   localparam int ARG_WIDTH = 32;
   localparam int ARG_BITS  = 32;
   localparam int EFF_WIDTH = (ARG_WIDTH > ARG_BITS) ? ARG_BITS :
                              ((ARG_WIDTH < 1) ? 1 : ARG_WIDTH);

   // Digit counts: decimal digits of the largest magnitude, and hex digits.
   localparam int DEC_DIGITS = (EFF_WIDTH * 1233) / 4096 + 1;
   localparam int HEX_DIGITS = (EFF_WIDTH + 3) / 4;
   localparam int NUM_DIGITS = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
   localparam int BCD_BITS   = NUM_DIGITS * 4;
   localparam int CNT_BITS   = $clog2(EFF_WIDTH + 1);
   localparam int LEFT_BITS  = $clog2(NUM_DIGITS + 1);

   // Character codes.
   localparam logic [7:0] CH_NUL         = 8'h00;
   localparam logic [7:0] CH_PCT         = 8'h25;
   localparam logic [7:0] CH_D           = 8'h64;
   localparam logic [7:0] CH_X           = 8'h78;
   localparam logic [7:0] CH_MINUS       = 8'h2d;
   localparam logic [7:0] CH_ZERO        = 8'h30;
   localparam logic [7:0] HEX_ALPHA_BASE = 8'h61 - 8'd10;
   localparam logic [3:0] NIBBLE_MASK    = 4'hf;

   // One request: a format byte with its argument.
   typedef struct packed {
      logic [7:0]         fmt_char;
      logic signed [31:0] arg_value;
      logic               fmt_end;
   } req_type;

   // One emitted byte.
   typedef struct packed {
      logic [7:0] out_char;
      logic       run_last;
   } rsp_type;

   // Start command for the digit converter.
   typedef struct packed {
      logic                 start;
      logic                 hex;
      logic [EFF_WIDTH-1:0] mag;
   } conv_cmd_type;

   // Status and digit stream from the digit converter.
   typedef struct packed {
      logic       busy;
      logic       valid;
      logic       last;
      logic [7:0] digit_char;
   } conv_stat_type;

endpackage

// ----- rtl/mpf_conv.sv -----
// Bit-serial binary to decimal or hex digit converter with a digit output stream.
module mpf_conv import mpf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  conv_cmd_type  cmd,
   input  logic          take,
   output conv_stat_type stat
);

   typedef enum logic [3:0] {
      C_IDLE  = 4'b0001,
      C_SHIFT = 4'b0010,
      C_TRIM  = 4'b0100,
      C_EMIT  = 4'b1000
   } conv_state_type;

   conv_state_type       state_ff, state_in;
   logic [EFF_WIDTH-1:0] bin_ff, bin_in;
   logic [BCD_BITS-1:0]  bcd_ff, bcd_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [LEFT_BITS-1:0] left_ff, left_in;
   logic [BCD_BITS-1:0]  bcd_corr;
   logic [3:0]           top_digit;

   // Add three to every decimal digit of five or more before each shift.
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_corr[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_corr[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   assign top_digit = bcd_ff[BCD_BITS-1 -: 4];

   // Digit stream toward the output register.
   assign stat.busy  = (state_ff != C_IDLE);
   assign stat.valid = (state_ff == C_EMIT);
   assign stat.last  = (left_ff == LEFT_BITS'(1));
   assign stat.digit_char = (top_digit > 4'd9) ? ({4'b0, top_digit} + HEX_ALPHA_BASE)
                                               : ({4'b0, top_digit} + CH_ZERO);

   // Sequencer: shift in the magnitude (decimal) or load it (hex), drop leading zeros, then emit digits.
   always_comb begin
      state_in = state_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      cnt_in   = cnt_ff;
      left_in  = left_ff;
      unique case (state_ff)
         C_IDLE: begin
            if (cmd.start) begin
               if (cmd.hex) begin
                  bcd_in   = BCD_BITS'(cmd.mag);
                  left_in  = LEFT_BITS'(NUM_DIGITS);
                  state_in = C_TRIM;
               end else begin
                  bin_in   = cmd.mag;
                  bcd_in   = '0;
                  cnt_in   = CNT_BITS'(EFF_WIDTH);
                  state_in = C_SHIFT;
               end
            end
         end
         C_SHIFT: begin
            bcd_in = {bcd_corr[BCD_BITS-2:0], bin_ff[EFF_WIDTH-1]};
            bin_in = bin_ff << 1;
            cnt_in = cnt_ff - CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(1)) begin
               left_in  = LEFT_BITS'(NUM_DIGITS);
               state_in = C_TRIM;
            end
         end
         C_TRIM: begin
            if (top_digit == 4'd0 && left_ff > LEFT_BITS'(1)) begin
               bcd_in  = bcd_ff << 4;
               left_in = left_ff - LEFT_BITS'(1);
            end else begin
               state_in = C_EMIT;
            end
         end
         C_EMIT: begin
            if (take) begin
               bcd_in  = bcd_ff << 4;
               left_in = left_ff - LEFT_BITS'(1);
               if (left_ff == LEFT_BITS'(1)) begin
                  state_in = C_IDLE;
               end
            end
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   // Control state is reset; the shift registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      cnt_ff  <= cnt_in;
      left_ff <= left_in;
   end

endmodule

// ----- rtl/mini_printf_int_formatter.sv -----
// Top level of the integer printf formatter.
//
// Usage: each request carries one format byte, an argument and an end flag.
// Ordinary bytes other than NUL are echoed as a one-byte run. A '%' emits
// nothing and, unless its end flag is set, arms the next byte: 'd' emits the
// signed decimal text of the argument, 'x' its lowercase hex text without
// leading zeros, anything else is dropped. The last byte of every run has
// run_last set. An echoed byte appears in the cycle after the request is
// accepted. A 'd' directive converts bit serially, one argument bit a cycle,
// then skips up to 9 leading zero digits, one a cycle, then emits one digit
// a cycle while the output is not stalled; a leading '-' is emitted at
// accept. An 'x' directive skips up to 9 zero digits and emits one digit a
// cycle while the output is not stalled. Requests are held off while a
// directive is converted or emitted. Reset clears the pending '%' and the
// output register. A stalled response holds its byte; a new request is taken
// only when the output register is free or being drained in that cycle.
module mini_printf_int_formatter import mpf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic                 pending_ff, pending_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_payload_ff, rsp_payload_in;
   logic                 accept, out_free, take;
   logic                 is_d, is_x, is_pct, is_echo, neg;
   logic [EFF_WIDTH-1:0] arg_v, neg_mag;
   conv_cmd_type         cmd;
   conv_stat_type        stat;

   // Handshake: one request at a time, taken while the converter is idle and the output register is free.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = stat.busy || !out_free;
   assign accept    = req_valid && !req_stall;
   assign take      = stat.valid && out_free;

   // Classify the byte against the pending percent.
   assign is_d    = pending_ff && (req_payload.fmt_char == CH_D);
   assign is_x    = pending_ff && (req_payload.fmt_char == CH_X);
   assign is_pct  = !pending_ff && (req_payload.fmt_char == CH_PCT);
   assign is_echo = !pending_ff && (req_payload.fmt_char != CH_PCT)
                    && (req_payload.fmt_char != CH_NUL);

   // Argument read at the working width; magnitude of a negative value.
   assign arg_v   = req_payload.arg_value[EFF_WIDTH-1:0];
   assign neg     = arg_v[EFF_WIDTH-1];
   assign neg_mag = (~arg_v) + EFF_WIDTH'(1);

   assign cmd.start = accept && (is_d || is_x);
   assign cmd.hex   = is_x;
   assign cmd.mag   = (is_d && neg) ? neg_mag : arg_v;

   mpf_conv u_conv (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .take  (take),
      .stat  (stat)
   );

   // Pending percent: set by an unarmed '%', cleared by any other byte or by the end flag.
   always_comb begin
      pending_in = pending_ff;
      if (accept) begin
         pending_in = is_pct && !req_payload.fmt_end;
      end
   end

   // Output register: echo byte or minus sign at accept, digits afterwards.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (accept && is_echo) begin
         rsp_valid_in            = 1'b1;
         rsp_payload_in.out_char = req_payload.fmt_char;
         rsp_payload_in.run_last = 1'b1;
      end else if (accept && is_d && neg) begin
         rsp_valid_in            = 1'b1;
         rsp_payload_in.out_char = CH_MINUS;
         rsp_payload_in.run_last = 1'b0;
      end else if (take) begin
         rsp_valid_in            = 1'b1;
         rsp_payload_in.out_char = stat.digit_char;
         rsp_payload_in.run_last = stat.last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ----- rtl/mpf_checker.sv -----
// Port-level checks for the integer printf formatter, bound to the top level.
module mpf_checker import mpf_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   // A stalled response keeps its byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   // Reset empties the output register.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // No request is taken while a response is stalled.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request taken while response stalled");

   // A run is finished before the next request is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.run_last |-> req_stall)
      else $error("request taken in the middle of a run");

endmodule

bind mini_printf_int_formatter mpf_checker u_mpf_checker (.*);
